// ----- hw/rtl/cutd_pkg.sv -----
// Shared types and constants for the frame difference cut detector.
// Holds the transaction payload structs, configuration codes and luma weights.
// No dependencies.
package cutd_pkg;

    localparam int GRAY_W  = 8;
    localparam int CNT_W   = 21;
    localparam int PAIR_W  = 24;
    localparam int SUM_W   = 22;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W  = CNT_W + CFG_W;

    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_NUM      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_DEN      = 2'd2;

    localparam logic [CFG_W-1:0] RST_DIFF_THRESHOLD = 8'd10;
    localparam logic [CFG_W-1:0] RST_RATIO_NUM      = 8'd4;
    localparam logic [CFG_W-1:0] RST_RATIO_DEN      = 8'd5;

    localparam logic [SUM_W-1:0] LUMA_R     = 22'd4899;
    localparam logic [SUM_W-1:0] LUMA_G     = 22'd9617;
    localparam logic [SUM_W-1:0] LUMA_B     = 22'd1868;
    localparam logic [SUM_W-1:0] LUMA_ROUND = 22'd8192;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    typedef struct packed {
        logic [7:0] chan_r;
        logic [7:0] chan_g;
        logic [7:0] chan_b;
        logic       end_of_frame;
    } t_pixel;

    typedef struct packed {
        logic              is_cut;
        logic [PAIR_W-1:0] pair_index;
        logic [CNT_W-1:0]  changed_count;
    } t_result;

    typedef struct packed {
        logic [CFG_W-1:0] diff_threshold;
        logic [CFG_W-1:0] ratio_num;
        logic [CFG_W-1:0] ratio_den;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0] changed;
        logic [CNT_W-1:0] total;
    } t_frame_sum;

endpackage

// ----- hw/rtl/cutd_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module cutd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/cutd_front.sv -----
// Pixel front end: gray conversion, frame store compare and changed-pixel tally.
// Depends on cutd_pkg and cutd_ram.
module cutd_front #(
    parameter int MAX_PIXELS = 16384
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  cutd_pkg::t_pixel            i_pix,
    input  logic [cutd_pkg::CFG_W-1:0]  i_threshold,
    output logic                        o_push,
    output cutd_pkg::t_frame_sum        o_sum
);
    import cutd_pkg::*;

    localparam int PW = $clog2(MAX_PIXELS + 1);
    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    logic [PW-1:0]     r_pos;
    logic [PW-1:0]     n_pos;
    logic              r_first;
    logic [PW-1:0]     r_tally;
    logic [PW-1:0]     n_tally;
    logic              r_a_valid;
    logic              r_wr_valid;

    logic [SUM_W-1:0]  r_a_prod_r;
    logic [SUM_W-1:0]  r_a_prod_g;
    logic [SUM_W-1:0]  r_a_prod_b;
    logic [AW-1:0]     r_a_addr;
    logic              r_a_inrange;
    logic              r_a_eof;
    logic              r_a_first;
    logic [PW-1:0]     r_a_total;
    logic [AW-1:0]     r_wr_addr;
    logic [GRAY_W-1:0] r_wr_data;

    logic              inrange;
    logic [PW-1:0]     pos_inc;
    logic [SUM_W-1:0]  sum;
    logic [GRAY_W-1:0] gray;
    logic [GRAY_W-1:0] ram_rdata;
    logic [GRAY_W-1:0] prev;
    logic [GRAY_W-1:0] diff;
    logic              changed;
    logic              we;

    assign inrange = r_pos < PW'(MAX_PIXELS);
    assign pos_inc = inrange ? r_pos + PW'(1) : r_pos;
    assign n_pos   = i_pix.end_of_frame ? '0 : pos_inc;

    assign sum     = r_a_prod_r + r_a_prod_g + r_a_prod_b + LUMA_ROUND;
    assign gray    = sum[SUM_W-1 -: GRAY_W];
    assign prev    = (r_wr_valid && (r_wr_addr == r_a_addr)) ? r_wr_data : ram_rdata;
    assign diff    = (gray > prev) ? gray - prev : prev - gray;
    assign changed = r_a_valid && r_a_inrange && !r_a_first && (diff > i_threshold);
    assign n_tally = r_tally + PW'(changed);
    assign we      = r_a_valid && r_a_inrange;

    cutd_ram #(
        .WIDTH (GRAY_W),
        .DEPTH (MAX_PIXELS)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_a_addr),
        .i_wdata (gray),
        .i_raddr (r_pos[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_first    <= 1'b1;
            r_tally    <= '0;
            r_a_valid  <= 1'b0;
            r_wr_valid <= 1'b0;
        end else begin
            r_a_valid  <= i_accept;
            r_wr_valid <= we;
            if (i_accept) begin
                r_pos <= n_pos;
                if (i_pix.end_of_frame) begin
                    r_first <= 1'b0;
                end
            end
            if (r_a_valid) begin
                r_tally <= r_a_eof ? '0 : n_tally;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a_prod_r  <= SUM_W'(i_pix.chan_r) * LUMA_R;
            r_a_prod_g  <= SUM_W'(i_pix.chan_g) * LUMA_G;
            r_a_prod_b  <= SUM_W'(i_pix.chan_b) * LUMA_B;
            r_a_addr    <= r_pos[AW-1:0];
            r_a_inrange <= inrange;
            r_a_eof     <= i_pix.end_of_frame;
            r_a_first   <= r_first;
            r_a_total   <= pos_inc;
        end
        r_wr_addr <= r_a_addr;
        r_wr_data <= gray;
    end

    assign o_push        = r_a_valid && r_a_eof && !r_a_first;
    assign o_sum.changed = CNT_W'(n_tally);
    assign o_sum.total   = CNT_W'(r_a_total);

endmodule

// ----- hw/rtl/cutd_fifo.sv -----
// Short queue of per-frame summaries between the front end and the back end.
// Depends on cutd_pkg.
module cutd_fifo (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  cutd_pkg::t_frame_sum       i_data,
    input  logic                       i_pop,
    output logic                       o_valid,
    output cutd_pkg::t_frame_sum       o_data,
    output logic [cutd_pkg::Q_CW-1:0]  o_count
);
    import cutd_pkg::*;

    t_frame_sum        r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_CW-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            r_count <= r_count + Q_CW'(i_push) - Q_CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_count;

endmodule

// ----- hw/rtl/cutd_back.sv -----
// Back end: cut decision from a frame summary, comparison numbering and result register.
// Depends on cutd_pkg.
module cutd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  cutd_pkg::t_frame_sum        i_sum,
    input  logic [cutd_pkg::CFG_W-1:0]  i_ratio_num,
    input  logic [cutd_pkg::CFG_W-1:0]  i_ratio_den,
    output logic                        o_pop,
    output logic                        o_res_valid,
    output cutd_pkg::t_result           o_res,
    input  logic                        i_res_stall
);
    import cutd_pkg::*;

    logic [PAIR_W-1:0] r_pair;
    logic              r_m_valid;
    logic [PROD_W-1:0] r_m_lhs;
    logic [PROD_W-1:0] r_m_rhs;
    logic [PAIR_W-1:0] r_m_pair;
    logic [CNT_W-1:0]  r_m_changed;
    logic              r_o_valid;
    t_result           r_o_res;

    logic              m_move;
    logic              pop;

    assign m_move = r_m_valid && (!r_o_valid || !i_res_stall);
    assign pop    = i_valid && (!r_m_valid || m_move);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair    <= '0;
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_pair    <= r_pair + PAIR_W'(1);
                r_m_valid <= 1'b1;
            end else if (m_move) begin
                r_m_valid <= 1'b0;
            end
            if (m_move) begin
                r_o_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_m_lhs     <= PROD_W'(i_sum.changed) * PROD_W'(i_ratio_den);
            r_m_rhs     <= PROD_W'(i_sum.total) * PROD_W'(i_ratio_num);
            r_m_pair    <= r_pair;
            r_m_changed <= i_sum.changed;
        end
        if (m_move) begin
            r_o_res.is_cut        <= (r_m_lhs > r_m_rhs);
            r_o_res.pair_index    <= r_m_pair;
            r_o_res.changed_count <= r_m_changed;
        end
    end

    assign o_pop       = pop;
    assign o_res_valid = r_o_valid;
    assign o_res       = r_o_res;

endmodule

// ----- hw/rtl/frame_difference_cut_detector_unit.sv -----
// Top level of the frame difference cut detector: configuration registers,
// input flow control and the front end, summary queue and back end.
// Depends on cutd_pkg, cutd_front, cutd_fifo and cutd_back.
//
//   Channel   Direction   Handshake                     Payload
//   pixel     in          i_pix_valid / o_pix_stall     i_pix (t_pixel)
//   result    out         o_res_valid / i_res_stall     o_res (t_result)
//   config    in          i_cfg_we                      i_cfg_idx, i_cfg_data
//
// One pixel transaction is taken per clock while o_pix_stall is low; the frame store
// has one read and one write port, registered read data and a write-to-read bypass
// for its read-compare-write. A result passes the front end stage, the summary queue
// and the back end's product and result registers after the frame's last transaction.
// The summary queue holds four frame results; o_pix_stall rises only when it and the
// in-flight frame end would fill it, which needs a result stall several frames long.
// Reset is synchronous and active low; the frame store needs no clearing.
module frame_difference_cut_detector_unit #(
    parameter int MAX_PIXELS = 16384
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_pix_valid,
    output logic                            o_pix_stall,
    input  cutd_pkg::t_pixel                i_pix,
    output logic                            o_res_valid,
    input  logic                            i_res_stall,
    output cutd_pkg::t_result               o_res,
    input  logic                            i_cfg_we,
    input  logic [cutd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cutd_pkg::CFG_W-1:0]      i_cfg_data
);
    import cutd_pkg::*;

    t_cfg             r_cfg;
    logic             accept;
    logic             push;
    t_frame_sum       push_sum;
    logic             q_valid;
    t_frame_sum       q_data;
    logic [Q_CW-1:0]  q_count;
    logic             pop;
    logic [Q_CW:0]    occupancy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.diff_threshold <= RST_DIFF_THRESHOLD;
            r_cfg.ratio_num      <= RST_RATIO_NUM;
            r_cfg.ratio_den      <= RST_RATIO_DEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DIFF_THRESHOLD: r_cfg.diff_threshold <= i_cfg_data;
                CFG_RATIO_NUM:      r_cfg.ratio_num      <= i_cfg_data;
                CFG_RATIO_DEN:      r_cfg.ratio_den      <= i_cfg_data;
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    assign occupancy   = {1'b0, q_count} + (Q_CW + 1)'(push);
    assign o_pix_stall = (occupancy >= (Q_CW + 1)'(Q_DEPTH));
    assign accept      = i_pix_valid && !o_pix_stall;

    cutd_front #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_pix       (i_pix),
        .i_threshold (r_cfg.diff_threshold),
        .o_push      (push),
        .o_sum       (push_sum)
    );

    cutd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_sum),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    cutd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_sum       (q_data),
        .i_ratio_num (r_cfg.ratio_num),
        .i_ratio_den (r_cfg.ratio_den),
        .o_pop       (pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_res_stall (i_res_stall)
    );

endmodule

// ----- hw/rtl/cutd_checker.sv -----
// Port-level checks for the frame difference cut detector, bound to the top level.
// Depends on cutd_pkg and frame_difference_cut_detector_unit.
module cutd_checker #(
    parameter int MAX_PIXELS = 16384
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_res_valid,
    input  logic               i_res_stall,
    input  cutd_pkg::t_result  o_res
);
    import cutd_pkg::*;

    logic [PAIR_W-1:0] r_last_pair;
    logic              r_seen;
    logic              res_take;

    assign res_take = o_res_valid && !i_res_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (res_take) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_last_pair <= o_res.pair_index;
        end
    end

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_stall) |=> (o_res_valid && $stable(o_res)))
        else $error("Stalled result transaction changed.");

    a_pair_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_take && r_seen) |-> (o_res.pair_index == r_last_pair + PAIR_W'(1)))
        else $error("Result pair index did not advance by one.");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.changed_count <= CNT_W'(MAX_PIXELS)))
        else $error("Changed count exceeds the frame store size.");

    a_cut_needs_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.is_cut) |-> (o_res.changed_count != '0))
        else $error("Cut flagged with no changed pixels.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("Result valid right after reset.");

endmodule

bind frame_difference_cut_detector_unit cutd_checker #(
    .MAX_PIXELS (MAX_PIXELS)
) u_cutd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_res_valid (o_res_valid),
    .i_res_stall (i_res_stall),
    .o_res       (o_res)
);

// ----- tb/sv/frame_difference_cut_detector_unit_test.sv -----
// Self-checking testbench for frame_difference_cut_detector_unit.
// Predicts each frame's cut verdict from the accepted pixels and checks every result transaction.
// Depends on cutd_pkg and the RTL of the cut detector.
`timescale 1ns / 100ps

module frame_difference_cut_detector_unit_test;
    import cutd_pkg::*;

    localparam int PIX_LIMIT = 16384;
    localparam int LUMA_FRAC = 14;
    localparam int FAR_OFF = 1000;
    localparam int REPORT_LIMIT = 10;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASES = 8;
    localparam int PHASE_PIXELS = 50;
    localparam int SEED_LEN = 128;

    class cut_tracker;
        bit [7:0]    luma_store [PIX_LIMIT];
        int unsigned position;
        int unsigned tally;
        bit          first_frame;
        bit [23:0]   comparison_no;
        t_cfg        cfg;
        t_result     verdicts_due [$];
        int          mismatches;

        function new();
            position = 0;
            tally = 0;
            first_frame = 1'b1;
            comparison_no = '0;
            cfg = '{RST_DIFF_THRESHOLD, RST_RATIO_NUM, RST_RATIO_DEN};
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_DIFF_THRESHOLD: cfg.diff_threshold = data;
                CFG_RATIO_NUM:      cfg.ratio_num = data;
                CFG_RATIO_DEN:      cfg.ratio_den = data;
                default: ;
            endcase
        endfunction

        function void note_pixel(t_pixel px);
            int unsigned      weighted;
            bit [7:0]         luma;
            bit [7:0]         prev;
            bit [7:0]         diff;
            longint unsigned  lhs;
            longint unsigned  rhs;
            t_result          verdict;
            weighted = int'(px.chan_r) * LUMA_R + int'(px.chan_g) * LUMA_G
                     + int'(px.chan_b) * LUMA_B + LUMA_ROUND;
            luma = 8'(weighted >> LUMA_FRAC);
            if (position < PIX_LIMIT) begin
                prev = luma_store[position];
                diff = (luma > prev) ? luma - prev : prev - luma;
                if (!first_frame && diff > cfg.diff_threshold) begin
                    tally++;
                end
                luma_store[position] = luma;
                position++;
            end
            if (px.end_of_frame) begin
                if (!first_frame) begin
                    lhs = longint'(tally) * cfg.ratio_den;
                    rhs = longint'(position) * cfg.ratio_num;
                    verdict.is_cut = (lhs > rhs);
                    verdict.pair_index = comparison_no;
                    verdict.changed_count = CNT_W'(tally);
                    verdicts_due.insert(verdicts_due.size(), verdict);
                    comparison_no++;
                end
                position = 0;
                tally = 0;
                first_frame = 1'b0;
            end
        endfunction

        function void check_verdict(t_result got);
            t_result want;
            if (verdicts_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: unexpected result cut=%0d pair=%0d changed=%0d",
                             $time, got.is_cut, got.pair_index, got.changed_count);
                end
            end else begin
                want = verdicts_due.pop_front();
                if (got.is_cut !== want.is_cut || got.pair_index !== want.pair_index ||
                    got.changed_count !== want.changed_count) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: result mismatch expected cut=%0d pair=%0d changed=%0d",
                                 $time, want.is_cut, want.pair_index, want.changed_count);
                        $display("%0t:                 actual   cut=%0d pair=%0d changed=%0d",
                                 $time, got.is_cut, got.pair_index, got.changed_count);
                    end
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_pix_valid = 1'b0;
    logic                  o_pix_stall;
    t_pixel                i_pix = '0;
    logic                  o_res_valid;
    logic                  i_res_stall = 1'b0;
    t_result               o_res;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_DIFF_THRESHOLD;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    cut_tracker tracker = new();
    int burst_left = 0;
    int stall_span = 0;
    int stall_pct = 0;

    frame_difference_cut_detector_unit #(
        .MAX_PIXELS(PIX_LIMIT)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_pix_valid(i_pix_valid),
        .o_pix_stall(o_pix_stall),
        .i_pix(i_pix),
        .o_res_valid(o_res_valid),
        .i_res_stall(i_res_stall),
        .o_res(o_res),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_pix_valid && !o_pix_stall) begin
                tracker.note_pixel(i_pix);
            end
            if (o_res_valid && !i_res_stall) begin
                tracker.check_verdict(o_res);
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_span = $urandom_range(1, 64);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 30;
                2: stall_pct = 70;
                default: stall_pct = 100;
            endcase
        end
        stall_span--;
        i_res_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_pixel random_pixel(bit eof);
        return '{pick_channel(), pick_channel(), pick_channel(), eof};
    endfunction

    function automatic logic [7:0] shifted_gray(int k, int off);
        int v;
        v = tracker.luma_store[k];
        if (off == FAR_OFF) begin
            v = (v < 128) ? 255 : 0;
        end else begin
            v = v + off;
        end
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    function automatic int pick_frame_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(1, 8);
        if (roll < 95) return $urandom_range(9, 40);
        return $urandom_range(41, 120);
    endfunction

    task automatic push_pixel(input t_pixel px);
        if (burst_left == 0) begin
            i_pix_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_pix_valid <= 1'b1;
        i_pix <= px;
        do @(posedge i_clk); while (o_pix_stall);
    endtask

    task automatic send_shifted_frame(input int plan[$]);
        logic [7:0] v;
        foreach (plan[k]) begin
            v = shifted_gray(k, plan[k]);
            push_pixel('{v, v, v, k == plan.size() - 1});
        end
    endtask

    task automatic send_frame(input int len, input int far_pct);
        int         span;
        int         off;
        logic [7:0] v;
        for (int k = 0; k < len; k++) begin
            if (k >= PIX_LIMIT || $urandom_range(0, 99) < far_pct) begin
                push_pixel(random_pixel(k == len - 1));
            end else begin
                span = int'(tracker.cfg.diff_threshold) + 2;
                off = int'($urandom_range(0, 2 * span)) - span;
                v = shifted_gray(k, off);
                push_pixel('{v, v, v, k == len - 1});
            end
        end
    endtask

    task automatic drain();
        i_pix_valid <= 1'b0;
        while (tracker.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] num,
                                input logic [CFG_W-1:0] den);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [CFG_W-1:0]     val [3];
        idx = '{CFG_DIFF_THRESHOLD, CFG_RATIO_NUM, CFG_RATIO_DEN};
        val = '{thr, num, den};
        for (int n = 0; n < 3; n++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx[n];
            i_cfg_data <= val[n];
            @(posedge i_clk);
            tracker.set_reg(idx[n], val[n]);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [23:0] seed_colors [8];
        logic [7:0]  thr;
        logic [7:0]  num;
        logic [7:0]  den;
        int          sent;
        int          len;
        seed_colors = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                        24'h0000FF, 24'h808080, 24'h010203, 24'hFEFDFC};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first frame is longer than any later frame so that every compared position
        // holds a value.
        for (int k = 0; k < SEED_LEN; k++) begin
            if (k < 8) begin
                push_pixel({seed_colors[k], 1'b0});
            end else begin
                push_pixel(random_pixel(k == SEED_LEN - 1));
            end
        end
        send_shifted_frame('{FAR_OFF, FAR_OFF, 10, 11, -10, -11, 0, 0, 0, 0});
        send_shifted_frame('{FAR_OFF, FAR_OFF, FAR_OFF, FAR_OFF, 0});
        send_shifted_frame('{FAR_OFF});
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    thr = 8'd0;
                    num = 8'd0;
                    den = 8'd1;
                end
                1: begin
                    thr = 8'd255;
                    num = 8'd255;
                    den = 8'd255;
                end
                2: begin
                    thr = 8'($urandom_range(0, 40));
                    num = 8'($urandom_range(0, 255));
                    den = 8'd0;
                end
                default: begin
                    thr = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 60));
                    num = 8'($urandom_range(0, 255));
                    den = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                end
            endcase
            program_regs(thr, num, den);
            sent = 0;
            while (sent < PHASE_PIXELS) begin
                len = pick_frame_len();
                send_frame(len, $urandom_range(0, 100));
                sent += len;
            end
            drain();
        end

        if (tracker.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
